[hw/rtl/slc_pkg.sv]
// Shared constants, types and codes for the set-associative LRU tag store.
// No dependencies; every other file but slc_ram takes names from here by scope.
`default_nettype none
package slc_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int NUM_SETS     = 1 << MAX_SET_BITS;
	localparam int NUM_LINES    = NUM_SETS * MAX_WAYS;
	localparam int SET_W        = MAX_SET_BITS;
	localparam int WAY_W        = $clog2(MAX_WAYS);
	localparam int WCNT_W       = $clog2(MAX_WAYS + 1);
	localparam int LINE_W       = SET_W + WAY_W;
	localparam int RANK_W       = 3;
	localparam int META_W       = MAX_WAYS * (1 + RANK_W);

	localparam int MODE_W       = 2;
	localparam int ADDR_W       = 64;
	localparam int TAG_W        = 64;
	localparam int CNT_W        = 32;
	localparam int HITS_W       = 2;

	localparam int SETB_W       = 3;
	localparam int BLKB_W       = 6;
	localparam int WAYS_W       = 4;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;
	localparam int REG_IDX_W    = PADDR_W - 2;

	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_STORE  = 2'd1,
		MODE_MODIFY = 2'd2,
		MODE_FETCH  = 2'd3
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SET_BITS   = 2'd0,
		REG_BLOCK_BITS = 2'd1,
		REG_WAYS       = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_LOOK   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/slc_if.sv]
// Request and response channel interfaces for the LRU tag store.
// Depends on slc_pkg for field widths.
`default_nettype none
interface slc_req_if;
	logic                       valid;
	logic                       ready;
	logic [slc_pkg::MODE_W-1:0] mode;
	logic [slc_pkg::ADDR_W-1:0] address;
	modport source (output valid, output mode, output address, input ready);
	modport sink (input valid, input mode, input address, output ready);
endinterface

interface slc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       was_miss;
	logic                       was_eviction;
	logic [slc_pkg::HITS_W-1:0] hits_here;
	logic [slc_pkg::CNT_W-1:0]  hit_total;
	logic [slc_pkg::CNT_W-1:0]  miss_total;
	logic [slc_pkg::CNT_W-1:0]  eviction_total;
	modport source (output valid, output was_miss, output was_eviction, output hits_here,
		output hit_total, output miss_total, output eviction_total, input ready);
	modport sink (input valid, input was_miss, input was_eviction, input hits_here,
		input hit_total, input miss_total, input eviction_total, output ready);
endinterface
`default_nettype wire

[hw/rtl/slc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module slc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/set_assoc_lru_cache_sim_core.sv]
// Sequence: a fetch request answers in the cycle after acceptance; a lookup passes decode,
// then compares ways in order (up to the hit way, or all ways in use on a miss), then updates.
// One tag compare per cycle against the tag RAM port; a modify adds no compare step.
// Throughput: one request at a time; ready returns the cycle after the response is taken.
// Reset (arst_n low, async): counters zero, state and config registers to defaults, per-set valid flags
// cleared at once, so every line reads invalid with rank zero; no clearing pass.
`default_nettype none
module set_assoc_lru_cache_sim_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	slc_req_if.sink                              req,
	slc_rsp_if.source                            rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [slc_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [slc_pkg::PDATA_W-1:0]     pwdata,
	output logic      [slc_pkg::PDATA_W-1:0]     prdata,
	output logic                                 pready
);

	slc_pkg::state_t state_q, state_d;

	logic [slc_pkg::SETB_W-1:0]  set_bits_q;
	logic [slc_pkg::BLKB_W-1:0]  block_bits_q;
	logic [slc_pkg::WAYS_W-1:0]  ways_in_use_q;

	logic [slc_pkg::MODE_W-1:0]  mode_q;
	logic [slc_pkg::ADDR_W-1:0]  addr_q;
	logic [slc_pkg::SET_W-1:0]   set_q;
	logic [slc_pkg::TAG_W-1:0]   tag_q;
	logic [slc_pkg::WAY_W-1:0]   way_q;
	logic [slc_pkg::WAY_W-1:0]   tgt_q;
	logic                        hit_q;
	logic [slc_pkg::NUM_SETS-1:0] rowv_q;

	logic [slc_pkg::CNT_W-1:0]   hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic                        was_miss_q, was_evict_q;
	logic [slc_pkg::HITS_W-1:0]  hits_here_q;

	// configuration port
	logic                         cfg_wr;
	logic [slc_pkg::REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[slc_pkg::PADDR_W-1:2];

	always_comb begin
		case (reg_idx)
			slc_pkg::REG_SET_BITS:   prdata = slc_pkg::PDATA_W'(set_bits_q);
			slc_pkg::REG_BLOCK_BITS: prdata = slc_pkg::PDATA_W'(block_bits_q);
			slc_pkg::REG_WAYS:       prdata = slc_pkg::PDATA_W'(ways_in_use_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= '0;
			block_bits_q  <= '0;
			ways_in_use_q <= slc_pkg::WAYS_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				slc_pkg::REG_SET_BITS:   set_bits_q    <= pwdata[slc_pkg::SETB_W-1:0];
				slc_pkg::REG_BLOCK_BITS: block_bits_q  <= pwdata[slc_pkg::BLKB_W-1:0];
				slc_pkg::REG_WAYS:       ways_in_use_q <= pwdata[slc_pkg::WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [slc_pkg::SETB_W-1:0]  sb;
	logic [slc_pkg::WCNT_W-1:0]  ways;
	logic [slc_pkg::WAY_W-1:0]   ways_last;
	logic [slc_pkg::ADDR_W-1:0]  block_d;
	logic [slc_pkg::SET_W-1:0]   set_d;
	logic [slc_pkg::TAG_W-1:0]   tag_d;

	always_comb begin
		sb = (set_bits_q > slc_pkg::SETB_W'(slc_pkg::MAX_SET_BITS)) ?
			slc_pkg::SETB_W'(slc_pkg::MAX_SET_BITS) : set_bits_q;
		if (ways_in_use_q == '0) begin
			ways = slc_pkg::WCNT_W'(1);
		end else if (ways_in_use_q > slc_pkg::WAYS_W'(slc_pkg::MAX_WAYS)) begin
			ways = slc_pkg::WCNT_W'(slc_pkg::MAX_WAYS);
		end else begin
			ways = slc_pkg::WCNT_W'(ways_in_use_q);
		end
		ways_last = slc_pkg::WAY_W'(ways - slc_pkg::WCNT_W'(1));
		block_d   = addr_q >> block_bits_q;
		set_d     = block_d[slc_pkg::SET_W-1:0] & ~({slc_pkg::SET_W{1'b1}} << sb);
		tag_d     = block_d >> sb;
	end

	// set metadata RAM: valid bits and ranks of one set per word
	logic                        meta_we, meta_re;
	logic [slc_pkg::META_W-1:0]  meta_wdata, meta_rdata;
	logic                        tag_we, tag_re;
	logic [slc_pkg::LINE_W-1:0]  tag_waddr, tag_raddr;
	logic [slc_pkg::TAG_W-1:0]   tag_rdata;

	slc_ram #(.WIDTH(slc_pkg::META_W), .DEPTH(slc_pkg::NUM_SETS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (set_q),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (set_d),
		.rdata (meta_rdata)
	);

	slc_ram #(.WIDTH(slc_pkg::TAG_W), .DEPTH(slc_pkg::NUM_LINES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_q),
		.re    (tag_re),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	// unpack the current set
	logic [slc_pkg::MAX_WAYS-1:0] vld;
	logic [slc_pkg::RANK_W-1:0]   rank [slc_pkg::MAX_WAYS];

	always_comb begin
		for (int i = 0; i < slc_pkg::MAX_WAYS; i++) begin
			vld[i]  = rowv_q[set_q] && meta_rdata[i];
			rank[i] = rowv_q[set_q] ?
				meta_rdata[slc_pkg::MAX_WAYS + i*slc_pkg::RANK_W +: slc_pkg::RANK_W] : '0;
		end
	end

	// victim: lowest invalid way, else highest rank, lowest way on ties
	logic [slc_pkg::WAY_W-1:0] victim;
	logic                      found_inv;

	always_comb begin
		victim    = '0;
		found_inv = 1'b0;
		for (int i = 0; i < slc_pkg::MAX_WAYS; i++) begin
			if (slc_pkg::WCNT_W'(i) < ways && !found_inv) begin
				if (!vld[i]) begin
					victim    = slc_pkg::WAY_W'(i);
					found_inv = 1'b1;
				end else if (rank[i] > rank[victim]) begin
					victim = slc_pkg::WAY_W'(i);
				end
			end
		end
	end

	// compare step
	logic hit_now, look_last;

	assign hit_now   = vld[way_q] && (tag_rdata == tag_q);
	assign look_last = (way_q == ways_last);

	// LRU update of the target way
	logic                         tgt_was_valid;
	logic [slc_pkg::RANK_W-1:0]   tgt_rank;
	logic [slc_pkg::MAX_WAYS-1:0] vld_new;
	logic [slc_pkg::MAX_WAYS*slc_pkg::RANK_W-1:0] rank_new;

	always_comb begin
		tgt_was_valid = vld[tgt_q];
		tgt_rank      = rank[tgt_q];
		vld_new       = vld;
		vld_new[tgt_q] = 1'b1;
		for (int i = 0; i < slc_pkg::MAX_WAYS; i++) begin
			rank_new[i*slc_pkg::RANK_W +: slc_pkg::RANK_W] = rank[i];
			if (slc_pkg::WAY_W'(i) == tgt_q) begin
				rank_new[i*slc_pkg::RANK_W +: slc_pkg::RANK_W] = '0;
			end else if (slc_pkg::WCNT_W'(i) < ways && vld[i] &&
					(!tgt_was_valid || rank[i] < tgt_rank) && rank[i] != slc_pkg::RANK_MAX) begin
				rank_new[i*slc_pkg::RANK_W +: slc_pkg::RANK_W] = rank[i] + slc_pkg::RANK_W'(1);
			end
		end
	end

	assign meta_we    = (state_q == slc_pkg::ST_UPDATE);
	assign meta_wdata = {rank_new, vld_new};
	assign meta_re    = (state_q == slc_pkg::ST_DECODE);
	assign tag_we     = (state_q == slc_pkg::ST_UPDATE) && !hit_q;
	assign tag_waddr  = {set_q, tgt_q};
	assign tag_re     = (state_q == slc_pkg::ST_DECODE) || (state_q == slc_pkg::ST_LOOK);
	assign tag_raddr  = (state_q == slc_pkg::ST_DECODE) ? {set_d, slc_pkg::WAY_W'(0)} :
		{set_q, way_q + slc_pkg::WAY_W'(1)};

	// saturating counters
	logic                        evict_now;
	logic [1:0]                  hit_add;

	function automatic logic [slc_pkg::CNT_W-1:0] sat_add(
		input logic [slc_pkg::CNT_W-1:0] v, input logic [1:0] a);
		logic [slc_pkg::CNT_W:0] s;
		s = {1'b0, v} + (slc_pkg::CNT_W+1)'(a);
		return s[slc_pkg::CNT_W] ? '1 : s[slc_pkg::CNT_W-1:0];
	endfunction

	assign evict_now = !hit_q && tgt_was_valid;
	assign hit_add   = 2'(hit_q) + 2'(mode_q == slc_pkg::MODE_MODIFY);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			slc_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.mode == slc_pkg::MODE_FETCH) ? slc_pkg::ST_RESP :
						slc_pkg::ST_DECODE;
				end
			end
			slc_pkg::ST_DECODE: state_d = slc_pkg::ST_LOOK;
			slc_pkg::ST_LOOK: begin
				if (hit_now || look_last) begin
					state_d = slc_pkg::ST_UPDATE;
				end
			end
			slc_pkg::ST_UPDATE: state_d = slc_pkg::ST_RESP;
			slc_pkg::ST_RESP: begin
				if (rsp.ready) begin
					state_d = slc_pkg::ST_IDLE;
				end
			end
			default: state_d = slc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slc_pkg::ST_IDLE;
			rowv_q      <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == slc_pkg::ST_UPDATE) begin
				rowv_q[set_q] <= 1'b1;
				hit_cnt_q     <= sat_add(hit_cnt_q, hit_add);
				miss_cnt_q    <= sat_add(miss_cnt_q, 2'(!hit_q));
				evict_cnt_q   <= sat_add(evict_cnt_q, 2'(evict_now));
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			slc_pkg::ST_IDLE: begin
				mode_q      <= req.mode;
				addr_q      <= req.address;
				was_miss_q  <= 1'b0;
				was_evict_q <= 1'b0;
				hits_here_q <= '0;
			end
			slc_pkg::ST_DECODE: begin
				set_q <= set_d;
				tag_q <= tag_d;
				way_q <= '0;
			end
			slc_pkg::ST_LOOK: begin
				if (hit_now) begin
					tgt_q <= way_q;
					hit_q <= 1'b1;
				end else if (look_last) begin
					tgt_q <= victim;
					hit_q <= 1'b0;
				end else begin
					way_q <= way_q + slc_pkg::WAY_W'(1);
				end
			end
			slc_pkg::ST_UPDATE: begin
				was_miss_q  <= !hit_q;
				was_evict_q <= evict_now;
				hits_here_q <= hit_add;
			end
			default: ;
		endcase
	end

	assign req.ready          = (state_q == slc_pkg::ST_IDLE);
	assign rsp.valid          = (state_q == slc_pkg::ST_RESP);
	assign rsp.was_miss       = was_miss_q;
	assign rsp.was_eviction   = was_evict_q;
	assign rsp.hits_here      = hits_here_q;
	assign rsp.hit_total      = hit_cnt_q;
	assign rsp.miss_total     = miss_cnt_q;
	assign rsp.eviction_total = evict_cnt_q;

endmodule
`default_nettype wire

[hw/rtl/slc_checker.sv]
// Port-level assertions for the LRU tag store, bound to the top level.
// Depends on slc_pkg and set_assoc_lru_cache_sim_core.
`default_nettype none
module slc_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic                       was_miss,
	input wire logic                       was_eviction,
	input wire logic [slc_pkg::HITS_W-1:0] hits_here,
	input wire logic [slc_pkg::CNT_W-1:0]  hit_total
);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |=> !rsp_valid)
		else $error("response repeated");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && was_eviction |-> was_miss && hits_here != 2'd2)
		else $error("eviction without miss");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_total))
		else $error("stalled response changed");

endmodule

bind set_assoc_lru_cache_sim_core slc_checker u_slc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.was_miss     (rsp.was_miss),
	.was_eviction (rsp.was_eviction),
	.hits_here    (rsp.hits_here),
	.hit_total    (rsp.hit_total)
);
`default_nettype wire

[sim/set_assoc_lru_cache_sim_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the set-associative LRU tag store: directed table, then random phases.
// Uses slc_pkg and the slc_req_if / slc_rsp_if channel interfaces from the RTL.
module set_assoc_lru_cache_sim_core_tb;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int HOLD_CYCLES     = 300;
	localparam int PHASES          = 12;
	localparam int LOOKUPS_PER_PHS = 100;

	typedef struct packed {
		logic                       was_miss;
		logic                       was_eviction;
		logic [slc_pkg::HITS_W-1:0] hits_here;
		logic [slc_pkg::CNT_W-1:0]  hit_total;
		logic [slc_pkg::CNT_W-1:0]  miss_total;
		logic [slc_pkg::CNT_W-1:0]  eviction_total;
	} access_result_t;

	typedef struct packed {
		bit                  is_setting;
		slc_pkg::reg_idx_t   reg_sel;
		logic [31:0]         value;
		slc_pkg::mode_t      mode;
		logic [63:0]         address;
		bit                  typed;
		access_result_t      result;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [slc_pkg::PADDR_W-1:0] paddr;
	logic [slc_pkg::PDATA_W-1:0] pwdata;
	logic [slc_pkg::PDATA_W-1:0] prdata;
	logic pready;

	slc_req_if req_ch ();
	slc_rsp_if rsp_ch ();

	set_assoc_lru_cache_sim_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bit            line_valid_q [slc_pkg::NUM_LINES];
	logic [63:0]   line_tag_q   [slc_pkg::NUM_LINES];
	logic [2:0]    line_rank_q  [slc_pkg::NUM_LINES];
	logic [31:0]   hit_cnt_q;
	logic [31:0]   miss_cnt_q;
	logic [31:0]   evict_cnt_q;
	logic [2:0]    cfg_set_bits;
	logic [5:0]    cfg_block_bits;
	logic [3:0]    cfg_ways;

	access_result_t pending_outcomes [$];
	stim_row_t      directed_rows [$];
	bit             cur_typed;
	access_result_t cur_typed_result;
	access_result_t predicted;
	access_result_t oldest;

	int  error_count;
	int  requests_sent;
	int  responses_seen;
	int  settings_used;
	int  cycle_count;
	int  hold_count;
	bit  gap_on;
	bit  stall_on;
	bit  hold_kick;

	initial clk = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic void promote_way(int base, int ways, int w);
		bit         was_valid;
		logic [2:0] old_rank;
		int         k;
		was_valid = line_valid_q[base + w];
		old_rank  = line_rank_q[base + w];
		for (int i = 0; i < ways; i++) begin
			k = base + i;
			if (i == w || !line_valid_q[k])
				continue;
			if (!was_valid || line_rank_q[k] < old_rank) begin
				if (line_rank_q[k] < slc_pkg::RANK_MAX)
					line_rank_q[k] = line_rank_q[k] + 3'd1;
			end
		end
		line_rank_q[base + w] = 3'd0;
	endfunction

	function automatic bit tag_lookup(logic [63:0] addr, output bit evicted);
		int          sb;
		int          ways;
		int          set_idx;
		int          base;
		int          victim;
		bit          found_invalid;
		logic [63:0] block;
		logic [63:0] tag;
		sb = (cfg_set_bits > slc_pkg::MAX_SET_BITS) ? slc_pkg::MAX_SET_BITS : int'(cfg_set_bits);
		ways = (cfg_ways == 0) ? 1 : int'(cfg_ways);
		if (ways > slc_pkg::MAX_WAYS)
			ways = slc_pkg::MAX_WAYS;
		block = addr >> cfg_block_bits;
		set_idx = int'(block & ((64'd1 << sb) - 64'd1));
		tag = block >> sb;
		base = set_idx * slc_pkg::MAX_WAYS;
		evicted = 1'b0;
		found_invalid = 1'b0;
		for (int i = 0; i < ways; i++) begin
			if (line_valid_q[base + i] && line_tag_q[base + i] == tag) begin
				hit_cnt_q = sat_inc(hit_cnt_q);
				promote_way(base, ways, i);
				return 1'b1;
			end
		end
		miss_cnt_q = sat_inc(miss_cnt_q);
		victim = 0;
		for (int i = 0; i < ways; i++) begin
			if (!line_valid_q[base + i]) begin
				victim = i;
				found_invalid = 1'b1;
				break;
			end
			if (line_rank_q[base + i] > line_rank_q[base + victim])
				victim = i;
		end
		if (!found_invalid) begin
			evict_cnt_q = sat_inc(evict_cnt_q);
			evicted = 1'b1;
		end
		promote_way(base, ways, victim);
		line_valid_q[base + victim] = 1'b1;
		line_tag_q[base + victim] = tag;
		return 1'b0;
	endfunction

	function automatic access_result_t predict_access(slc_pkg::mode_t m, logic [63:0] addr);
		access_result_t r;
		bit             ev;
		bit             ev2;
		r = '0;
		if (m != slc_pkg::MODE_FETCH) begin
			if (tag_lookup(addr, ev))
				r.hits_here = r.hits_here + 2'd1;
			else
				r.was_miss = 1'b1;
			r.was_eviction = ev;
			if (m == slc_pkg::MODE_MODIFY) begin
				if (tag_lookup(addr, ev2))
					r.hits_here = r.hits_here + 2'd1;
			end
		end
		r.hit_total      = hit_cnt_q;
		r.miss_total     = miss_cnt_q;
		r.eviction_total = evict_cnt_q;
		return r;
	endfunction

	function automatic access_result_t outcome(bit m, bit e, logic [1:0] h,
			logic [31:0] ht, logic [31:0] mt, logic [31:0] et);
		access_result_t r;
		r.was_miss       = m;
		r.was_eviction   = e;
		r.hits_here      = h;
		r.hit_total      = ht;
		r.miss_total     = mt;
		r.eviction_total = et;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at response %0d: %s got %0h want %0h", responses_seen, what, got, want);
		error_count++;
	endtask

	task automatic add_access(slc_pkg::mode_t m, logic [63:0] a);
		stim_row_t row;
		row = '0;
		row.mode = m;
		row.address = a;
		directed_rows.push_back(row);
	endtask

	task automatic add_checked(slc_pkg::mode_t m, logic [63:0] a, access_result_t r);
		stim_row_t row;
		row = '0;
		row.mode = m;
		row.address = a;
		row.typed = 1'b1;
		row.result = r;
		directed_rows.push_back(row);
	endtask

	task automatic add_setting(slc_pkg::reg_idx_t idx, logic [31:0] v);
		stim_row_t row;
		row = '0;
		row.is_setting = 1'b1;
		row.reg_sel = idx;
		row.value = v;
		directed_rows.push_back(row);
	endtask

	task automatic write_reg(slc_pkg::reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			slc_pkg::REG_SET_BITS:   cfg_set_bits = v[2:0];
			slc_pkg::REG_BLOCK_BITS: cfg_block_bits = v[5:0];
			slc_pkg::REG_WAYS:       cfg_ways = v[3:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_access(slc_pkg::mode_t m, logic [63:0] a, bit typed, access_result_t r);
		@(negedge clk);
		if (gap_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7))
				@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.mode = m;
		req_ch.address = a;
		cur_typed = typed;
		cur_typed_result = r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		requests_sent++;
	endtask

	function automatic logic [63:0] make_address();
		int          sb;
		int          bb;
		int          ways;
		logic [63:0] tag;
		logic [63:0] block;
		logic [63:0] offset;
		if ($urandom_range(0, 9) == 0)
			return {$urandom, $urandom};
		sb = (cfg_set_bits > slc_pkg::MAX_SET_BITS) ? slc_pkg::MAX_SET_BITS : int'(cfg_set_bits);
		bb = int'(cfg_block_bits);
		ways = (cfg_ways == 0) ? 1 :
			((cfg_ways > slc_pkg::MAX_WAYS) ? slc_pkg::MAX_WAYS : int'(cfg_ways));
		tag = 64'($urandom_range(0, 2 * ways + 1));
		block = (tag << sb) | 64'($urandom_range(0, (1 << sb) - 1));
		offset = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
		return (block << bb) | offset;
	endfunction

	function automatic slc_pkg::mode_t pick_mode();
		int p;
		p = $urandom_range(0, 99);
		if (p < 35)
			return slc_pkg::MODE_LOAD;
		if (p < 65)
			return slc_pkg::MODE_STORE;
		if (p < 90)
			return slc_pkg::MODE_MODIFY;
		return slc_pkg::MODE_FETCH;
	endfunction

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			predicted = predict_access(slc_pkg::mode_t'(req_ch.mode), req_ch.address);
			if (cur_typed)
				predicted = cur_typed_result;
			pending_outcomes.push_back(predicted);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("response with no request waiting", 64'd1, 64'd0);
			end else begin
				oldest = pending_outcomes.pop_front();
				if (rsp_ch.was_miss !== oldest.was_miss)
					report_mismatch("was_miss", 64'(rsp_ch.was_miss), 64'(oldest.was_miss));
				if (rsp_ch.was_eviction !== oldest.was_eviction)
					report_mismatch("was_eviction", 64'(rsp_ch.was_eviction),
						64'(oldest.was_eviction));
				if (rsp_ch.hits_here !== oldest.hits_here)
					report_mismatch("hits_here", 64'(rsp_ch.hits_here), 64'(oldest.hits_here));
				if (rsp_ch.hit_total !== oldest.hit_total)
					report_mismatch("hit_total", 64'(rsp_ch.hit_total), 64'(oldest.hit_total));
				if (rsp_ch.miss_total !== oldest.miss_total)
					report_mismatch("miss_total", 64'(rsp_ch.miss_total),
						64'(oldest.miss_total));
				if (rsp_ch.eviction_total !== oldest.eviction_total)
					report_mismatch("eviction_total", 64'(rsp_ch.eviction_total),
						64'(oldest.eviction_total));
			end
			responses_seen++;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_kick) begin
				rsp_ch.ready = 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(negedge clk);
					hold_count++;
				end
				hold_kick = 1'b0;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready = 1'b0;
				repeat ($urandom_range(1, 7))
					@(negedge clk);
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d responses pending", cycle_count,
			pending_outcomes.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		slc_pkg::mode_t m;
		logic [31:0]    sb_val;
		logic [31:0]    bb_val;
		logic [31:0]    ways_val;
		int             lookups;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = slc_pkg::MODE_LOAD;
		req_ch.address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_typed = 1'b0;
		cur_typed_result = '0;
		error_count = 0;
		requests_sent = 0;
		responses_seen = 0;
		settings_used = 0;
		hold_kick = 1'b0;
		gap_on = 1'b1;
		stall_on = 1'b1;
		for (int i = 0; i < slc_pkg::NUM_LINES; i++) begin
			line_valid_q[i] = 1'b0;
			line_tag_q[i] = '0;
			line_rank_q[i] = '0;
		end
		hit_cnt_q = '0;
		miss_cnt_q = '0;
		evict_cnt_q = '0;
		cfg_set_bits = 3'd0;
		cfg_block_bits = 6'd0;
		cfg_ways = 4'd1;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_checked(slc_pkg::MODE_FETCH, 64'd0,
			outcome(1'b0, 1'b0, 2'd0, 32'd0, 32'd0, 32'd0));
		add_checked(slc_pkg::MODE_LOAD, 64'd0,
			outcome(1'b1, 1'b0, 2'd0, 32'd0, 32'd1, 32'd0));
		add_checked(slc_pkg::MODE_LOAD, 64'd0,
			outcome(1'b0, 1'b0, 2'd1, 32'd1, 32'd1, 32'd0));
		add_checked(slc_pkg::MODE_STORE, '1,
			outcome(1'b1, 1'b1, 2'd0, 32'd1, 32'd2, 32'd1));
		add_checked(slc_pkg::MODE_MODIFY, 64'd0,
			outcome(1'b1, 1'b1, 2'd1, 32'd2, 32'd3, 32'd2));
		add_checked(slc_pkg::MODE_FETCH, '1,
			outcome(1'b0, 1'b0, 2'd0, 32'd2, 32'd3, 32'd2));
		add_setting(slc_pkg::REG_SET_BITS, 32'd7);
		add_setting(slc_pkg::REG_BLOCK_BITS, 32'd63);
		add_setting(slc_pkg::REG_WAYS, 32'd15);
		add_access(slc_pkg::MODE_LOAD, 64'h8000_0000_0000_0000);
		add_access(slc_pkg::MODE_LOAD, 64'd0);
		add_access(slc_pkg::MODE_MODIFY, '1);
		add_setting(slc_pkg::REG_SET_BITS, 32'd2);
		add_setting(slc_pkg::REG_BLOCK_BITS, 32'd4);
		add_setting(slc_pkg::REG_WAYS, 32'd4);
		add_access(slc_pkg::MODE_LOAD, 64'h000);
		add_access(slc_pkg::MODE_LOAD, 64'h040);
		add_access(slc_pkg::MODE_STORE, 64'h080);
		add_access(slc_pkg::MODE_LOAD, 64'h0C0);
		add_access(slc_pkg::MODE_LOAD, 64'h000);
		add_access(slc_pkg::MODE_MODIFY, 64'h100);
		add_setting(slc_pkg::REG_SET_BITS, 32'd0);
		add_setting(slc_pkg::REG_BLOCK_BITS, 32'd0);
		add_setting(slc_pkg::REG_WAYS, 32'd2);
		add_access(slc_pkg::MODE_LOAD, 64'hA);
		add_access(slc_pkg::MODE_LOAD, 64'hB);
		add_setting(slc_pkg::REG_WAYS, 32'd0);
		add_access(slc_pkg::MODE_LOAD, 64'hB);
		add_setting(slc_pkg::REG_WAYS, 32'd2);
		add_access(slc_pkg::MODE_LOAD, 64'hB);
		add_access(slc_pkg::MODE_STORE, 64'hC);
		add_access(slc_pkg::MODE_MODIFY, 64'h5555_AAAA_5555_AAAA);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_setting) begin
				write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
				settings_used++;
			end else begin
				send_access(directed_rows[i].mode, directed_rows[i].address,
					directed_rows[i].typed, directed_rows[i].result);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				sb_val = slc_pkg::MAX_SET_BITS;
				bb_val = 0;
				ways_val = slc_pkg::MAX_WAYS;
			end else if (phase == 1) begin
				sb_val = 0;
				bb_val = 0;
				ways_val = 1;
			end else begin
				sb_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
				bb_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
				ways_val = $urandom_range(0, 15);
			end
			write_reg(slc_pkg::REG_SET_BITS, sb_val);
			write_reg(slc_pkg::REG_BLOCK_BITS, bb_val);
			write_reg(slc_pkg::REG_WAYS, ways_val);
			settings_used++;
			gap_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
			stall_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (phase == 3)
				hold_kick = 1'b1;
			lookups = 0;
			while (lookups < LOOKUPS_PER_PHS) begin
				m = pick_mode();
				send_access(m, make_address(), 1'b0, '0);
				if (m != slc_pkg::MODE_FETCH)
					lookups++;
			end
		end

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch("responses never arrived", 64'd0, 64'(pending_outcomes.size()));

		$display("covered %0d requests over %0d register settings, %0d responses checked",
			requests_sent, settings_used, responses_seen);
		$display("predicted totals: %0d hits, %0d misses, %0d evictions; %0d mismatches",
			hit_cnt_q, miss_cnt_q, evict_cnt_q, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
